// ----- rtl/ipe_pkg.sv -----
package ipe_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  localparam int unsigned APB_AW = 3;
  localparam logic REG_IDX_MODE = 1'b0;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_OVF  = 3'd1,
    ERR_UNF  = 3'd2,
    ERR_DIV0 = 3'd3,
    ERR_INV  = 3'd4
  } err_e;

  // per-cell shift control: take_up loads from the cell nearer the top,
  // take_dn loads from the cell farther from the top
  typedef struct packed {
    logic take_up;
    logic take_dn;
  } stk_cmd_t;

endpackage

// ----- rtl/infix_postfix_engine_unit.sv -----
// Infix-to-postfix converter and postfix evaluator on one shifting stack.
// Input channel: ch_i/last_i under in_valid_i/in_ready_o, one character per
// item; last_i marks the final character of an expression.
// Output channel: out_char_o, result_value_o, is_value_o, error_code_o and
// end_of_run_o under out_valid_o/out_ready_i. An input item gives zero or
// more result items; end_of_run_o marks the final one of an expression.
// mode (APB register 0): 0 converts infix to postfix, 1 evaluates postfix.
// The stack is a row of STACK_DEPTH cells; a push or pop shifts the whole row
// by one place. Each item is accepted and then decoded; after that
//   convert: an operator pops and emits each entry of equal or higher
//   precedence, then is pushed; last flushes the remaining entries and finishes;
//   evaluate: + - * complete in decode; / waits for the radix-2 divider;
//   last emits the top value.
// in_ready_o is high only between items.
// Reset empties the stack and sets mode to 0. When the receiver stalls, the
// result waits in the output register and the engine holds until it drains.
module infix_postfix_engine_unit import ipe_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        ch_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_char_o,
  output logic [15:0]       result_value_o,
  output logic              is_value_o,
  output logic [2:0]        error_code_o,
  output logic              end_of_run_o
);

  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EXT_W = (W > 16) ? W : 16;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_POPS  = 6'b000100,
    S_FLUSH = 6'b001000,
    S_DIV   = 6'b010000,
    S_FINAL = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [SP_W-1:0] sp_q, sp_d;
  logic            mode_q;
  logic [7:0]      ch_q;
  logic            last_q;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_char_q;
  logic [15:0]     out_val_q;
  logic            out_isv_q;
  err_e            out_err_q;
  logic            out_eor_q;

  logic            emit;
  logic            can_emit;
  logic [7:0]      e_char;
  logic [15:0]     e_val;
  err_e            e_err;
  logic            e_eor;

  stk_cmd_t        cmd_top, cmd_rest;
  logic [W-1:0]    push_val;
  logic [W-1:0]    stk [STACK_DEPTH];
  logic [W-1:0]    top, nxt;

  logic            div_start;
  logic            div_done;
  logic [W-1:0]    quot;

  logic            is_dig, is_alpha, is_op;
  logic [1:0]      prec_in, prec_top;
  logic [W-1:0]    arith;
  logic [W-1:0]    prod;
  logic [EXT_W-1:0] top_ext;
  state_e          nxt_conv, nxt_eval;
  logic            cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_MODE);
  assign prdata = (paddr[2] == REG_IDX_MODE) ? {31'b0, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_wr) begin
      mode_q <= pwdata[0];
    end
  end

  // stack: a row of shifting cells, entry 0 is the top
  assign top = stk[0];
  assign nxt = stk[1];

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [W-1:0] up_w, dn_w;
    if (g == 0) begin : g_up_in
      assign up_w = push_val;
    end else begin : g_up_nb
      assign up_w = stk[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_dn_end
      assign dn_w = '0;
    end else begin : g_dn_nb
      assign dn_w = stk[g+1];
    end
    ipe_cell #(.W(W)) u_cell (
      .clk_i (clk_i),
      .cmd_i ((g == 0) ? cmd_top : cmd_rest),
      .up_i  (up_w),
      .dn_i  (dn_w),
      .val_o (stk[g])
    );
  end

  ipe_div #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (nxt),
    .divisor_i  (top),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // character classes
  assign is_dig   = (ch_q >= CH_0) && (ch_q <= CH_9);
  assign is_alpha = ((ch_q >= CH_LA) && (ch_q <= CH_LZ)) ||
                    ((ch_q >= CH_UA) && (ch_q <= CH_UZ));
  assign is_op    = (ch_q == CH_PLUS) || (ch_q == CH_MINUS) ||
                    (ch_q == CH_STAR) || (ch_q == CH_SLASH);
  assign prec_in  = ((ch_q == CH_STAR) || (ch_q == CH_SLASH)) ? 2'd2 :
                    ((ch_q == CH_PLUS) || (ch_q == CH_MINUS)) ? 2'd1 : 2'd0;
  assign prec_top = ((top == W'(CH_STAR)) || (top == W'(CH_SLASH))) ? 2'd2 :
                    ((top == W'(CH_PLUS)) || (top == W'(CH_MINUS))) ? 2'd1 : 2'd0;

  assign prod    = nxt * top;
  assign arith   = (ch_q == CH_PLUS)  ? (nxt + top) :
                   (ch_q == CH_MINUS) ? (nxt - top) : prod;
  assign top_ext = EXT_W'($signed(top));

  assign nxt_conv = last_q ? S_FLUSH : S_IDLE;
  assign nxt_eval = last_q ? S_FINAL : S_IDLE;
  assign can_emit = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    cmd_top   = '0;
    cmd_rest  = '0;
    push_val  = '0;
    emit      = 1'b0;
    e_char    = '0;
    e_val     = '0;
    e_err     = ERR_NONE;
    e_eor     = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (!mode_q) begin
          if (is_dig || is_alpha || !is_op) begin
            emit   = 1'b1;
            if (is_dig || is_alpha) begin
              e_char = ch_q;
            end else begin
              e_err  = ERR_INV;
            end
            e_eor  = last_q && (sp_q == '0);
            if (can_emit) begin
              state_d = nxt_conv;
            end
          end else begin
            state_d = S_POPS;
          end
        end else begin
          if (is_dig) begin
            if (sp_q != SP_W'(STACK_DEPTH)) begin
              cmd_top.take_up  = 1'b1;
              cmd_rest.take_up = 1'b1;
              push_val = W'(ch_q - CH_0);
              sp_d     = sp_q + 1'b1;
              state_d  = nxt_eval;
            end else begin
              emit  = 1'b1;
              e_err = ERR_OVF;
              if (can_emit) begin
                state_d = nxt_eval;
              end
            end
          end else if (!is_op) begin
            emit  = 1'b1;
            e_err = ERR_INV;
            if (can_emit) begin
              state_d = nxt_eval;
            end
          end else if (sp_q < SP_W'(2)) begin
            emit  = 1'b1;
            e_err = ERR_UNF;
            if (can_emit) begin
              state_d = nxt_eval;
            end
          end else if (ch_q == CH_SLASH) begin
            if (top == '0) begin
              emit  = 1'b1;
              e_err = ERR_DIV0;
              if (can_emit) begin
                state_d = nxt_eval;
              end
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end else begin
            cmd_top.take_up  = 1'b1;
            cmd_rest.take_dn = 1'b1;
            push_val = arith;
            sp_d     = sp_q - 1'b1;
            state_d  = nxt_eval;
          end
        end
      end
      S_POPS: begin
        if ((sp_q != '0) && (prec_top >= prec_in)) begin
          emit   = 1'b1;
          e_char = top[7:0];
          if (can_emit) begin
            cmd_top.take_dn  = 1'b1;
            cmd_rest.take_dn = 1'b1;
            sp_d = sp_q - 1'b1;
          end
        end else if (sp_q != SP_W'(STACK_DEPTH)) begin
          cmd_top.take_up  = 1'b1;
          cmd_rest.take_up = 1'b1;
          push_val = W'(ch_q);
          sp_d     = sp_q + 1'b1;
          state_d  = nxt_conv;
        end else begin
          emit  = 1'b1;
          e_err = ERR_OVF;
          if (can_emit) begin
            state_d = nxt_conv;
          end
        end
      end
      S_FLUSH: begin
        if (sp_q == '0) begin
          state_d = S_IDLE;
        end else begin
          emit   = 1'b1;
          e_char = top[7:0];
          e_eor  = (sp_q == SP_W'(1));
          if (can_emit) begin
            cmd_top.take_dn  = 1'b1;
            cmd_rest.take_dn = 1'b1;
            sp_d = sp_q - 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          cmd_top.take_up  = 1'b1;
          cmd_rest.take_dn = 1'b1;
          push_val = quot;
          sp_d     = sp_q - 1'b1;
          state_d  = nxt_eval;
        end
      end
      S_FINAL: begin
        emit  = 1'b1;
        e_eor = 1'b1;
        if (sp_q != '0) begin
          e_val = top_ext[15:0];
        end else begin
          e_err = ERR_UNF;
        end
        if (can_emit) begin
          sp_d    = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit && can_emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
    if (emit && can_emit) begin
      out_char_q <= e_char;
      out_val_q  <= e_val;
      out_isv_q  <= mode_q;
      out_err_q  <= e_err;
      out_eor_q  <= e_eor;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign result_value_o = out_val_q;
  assign is_value_o     = out_isv_q;
  assign error_code_o   = out_err_q;
  assign end_of_run_o   = out_eor_q;

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DEC)
    else $error("accepted item not decoded");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL) && can_emit |=> (sp_q == '0) && (state_q == S_IDLE))
    else $error("stack not emptied after final item");

  a_div_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> mode_q && (top != '0) && (sp_q >= SP_W'(2)))
    else $error("divide started without two operands and a nonzero divisor");
`endif

endmodule

// ----- rtl/ipe_cell.sv -----
module ipe_cell import ipe_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  stk_cmd_t     cmd_i,
  input  logic [W-1:0] up_i,
  input  logic [W-1:0] dn_i,
  output logic [W-1:0] val_o
);

  logic [W-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (cmd_i.take_up) begin
      val_d = up_i;
    end else if (cmd_i.take_dn) begin
      val_d = dn_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ----- rtl/ipe_div.sv -----
module ipe_div import ipe_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     q_q, q_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     dv_q, dv_d;
  logic             neg_q, neg_d;
  logic [W:0]       r_sh;
  logic [W:0]       diff;
  logic [W-1:0]     a_mag;
  logic [W-1:0]     b_mag;

  assign a_mag = dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign b_mag = divisor_i[W-1] ? (~divisor_i + 1'b1) : divisor_i;
  assign r_sh  = {rem_q, q_q[W-1]};
  assign diff  = r_sh - {1'b0, dv_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    q_d    = q_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      q_d    = a_mag;
      rem_d  = '0;
      dv_d   = b_mag;
      neg_d  = dividend_i[W-1] ^ divisor_i[W-1];
    end else if (busy_q) begin
      q_d   = {q_q[W-2:0], ~diff[W]};
      rem_d = diff[W] ? r_sh[W-1:0] : diff[W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~q_q + 1'b1) : q_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a running division");

  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q)
    else $error("divider stopped without done");
`endif

endmodule

// ----- dv/infix_postfix_engine_unit_tb.sv -----
module infix_postfix_engine_unit_tb;
  import ipe_pkg::*;

  localparam int STACK_DEPTH  = 32;
  localparam int NPHASE       = 8;
  localparam int PHASE_ITEMS  = 28;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 48;
  localparam int STALL_LIMIT  = 4000;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [APB_AW-1:0] MODE_ADDR = APB_AW'(4 * int'(REG_IDX_MODE));

  typedef logic [7:0] str_t[$];

  typedef struct packed {
    logic [7:0]  chr;
    logic [15:0] val;
    logic        isv;
    err_e        err;
    logic        eor;
  } res_t;

  typedef struct packed {
    logic        md;
    logic [7:0]  ch;
    logic        lst;
    logic        typed;
    logic [7:0]  w_chr;
    logic [15:0] w_val;
    logic        w_isv;
    err_e        w_err;
    logic        w_eor;
  } drow_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata, prdata;
  logic              pready;
  logic              in_valid_i, in_ready_o;
  logic [7:0]        ch_i;
  logic              last_i;
  logic              out_valid_o, out_ready_i;
  logic [7:0]        out_char_o;
  logic [15:0]       result_value_o;
  logic              is_value_o;
  logic [2:0]        error_code_o;
  logic              end_of_run_o;

  // shadow of the engine
  logic [15:0] stk [STACK_DEPTH];
  int          sp = 0;
  logic        mode_q = 1'b0;

  res_t pending_results[$];
  int   mismatches = 0;
  int   n_items = 0;
  int   n_results = 0;
  int   n_cfg = 0;
  int   stall_cnt = 0;
  bit   quiet = 1'b0;
  bit   hold_req = 1'b0;

  // directed: conversion ladder, invalid extremes, then evaluation corners
  drow_t dir_tab [25] = '{
    '{1'b0, CH_LA,        1'b0, 1'b1, CH_LA, 16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b0, CH_PLUS,      1'b0, 1'b0, 8'd0,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b0, CH_LA + 8'd1, 1'b0, 1'b1, CH_LA + 8'd1, 16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b0, CH_STAR,      1'b0, 1'b0, 8'd0,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b0, CH_UZ,        1'b0, 1'b1, CH_UZ, 16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b0, CH_MINUS,     1'b0, 1'b0, 8'd0,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b0, CH_9,         1'b0, 1'b1, CH_9,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b0, CH_SLASH,     1'b0, 1'b0, 8'd0,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b0, 8'h00,        1'b0, 1'b1, 8'd0,  16'd0, 1'b0, ERR_INV,  1'b0},
    '{1'b0, CH_UA,        1'b0, 1'b1, CH_UA, 16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b0, CH_0,         1'b1, 1'b0, 8'd0,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b0, 8'hFF,        1'b1, 1'b1, 8'd0,  16'd0, 1'b0, ERR_INV,  1'b1},
    '{1'b0, CH_LZ,        1'b1, 1'b1, CH_LZ, 16'd0, 1'b0, ERR_NONE, 1'b1},
    '{1'b1, CH_PLUS,      1'b0, 1'b1, 8'd0,  16'd0, 1'b1, ERR_UNF,  1'b0},
    '{1'b1, CH_LA,        1'b0, 1'b1, 8'd0,  16'd0, 1'b1, ERR_INV,  1'b0},
    '{1'b1, 8'hFF,        1'b1, 1'b0, 8'd0,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b1, CH_9,         1'b0, 1'b0, 8'd0,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b1, CH_0,         1'b0, 1'b0, 8'd0,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b1, CH_SLASH,     1'b0, 1'b1, 8'd0,  16'd0, 1'b1, ERR_DIV0, 1'b0},
    '{1'b1, CH_MINUS,     1'b0, 1'b0, 8'd0,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b1, CH_0 + 8'd7,  1'b0, 1'b0, 8'd0,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b1, CH_STAR,      1'b0, 1'b0, 8'd0,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b1, CH_0 + 8'd8,  1'b0, 1'b0, 8'd0,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b1, CH_SLASH,     1'b1, 1'b0, 8'd0,  16'd0, 1'b0, ERR_NONE, 1'b0},
    '{1'b1, CH_0 + 8'd5,  1'b1, 1'b1, 8'd0,  16'd5, 1'b1, ERR_NONE, 1'b1}
  };

  infix_postfix_engine_unit dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic int prio(logic [15:0] v);
    if (v == 16'(CH_PLUS) || v == 16'(CH_MINUS)) return 1;
    if (v == 16'(CH_STAR) || v == 16'(CH_SLASH)) return 2;
    return 0;
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_operand(logic [7:0] c);
    return is_num(c) || (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic res_t mk(logic [7:0] c, logic [15:0] v, logic iv, err_e e);
    res_t r;
    r.chr = c;
    r.val = v;
    r.isv = iv;
    r.err = e;
    r.eor = 1'b0;
    return r;
  endfunction

  // advance the shadow stack by one character, queue what it emits
  function automatic void engine_step(logic [7:0] c, logic l, bit keep);
    res_t   r[$];
    longint a, b, q;
    bit     ok;
    int     p;
    ok = 1'b1;
    q = 0;
    if (mode_q == 1'b0) begin
      if (is_operand(c)) begin
        r.push_back(mk(c, 16'd0, 1'b0, ERR_NONE));
      end else if (prio(16'(c)) > 0) begin
        p = prio(16'(c));
        while (sp > 0 && prio(stk[sp-1]) >= p) begin
          sp--;
          r.push_back(mk(stk[sp][7:0], 16'd0, 1'b0, ERR_NONE));
        end
        if (sp < STACK_DEPTH) begin
          stk[sp] = 16'(c);
          sp++;
        end else begin
          r.push_back(mk(8'd0, 16'd0, 1'b0, ERR_OVF));
        end
      end else begin
        r.push_back(mk(8'd0, 16'd0, 1'b0, ERR_INV));
      end
      if (l) begin
        while (sp > 0) begin
          sp--;
          r.push_back(mk(stk[sp][7:0], 16'd0, 1'b0, ERR_NONE));
        end
        r[r.size()-1].eor = 1'b1;
      end
    end else begin
      if (is_num(c)) begin
        if (sp < STACK_DEPTH) begin
          stk[sp] = 16'(c - CH_0);
          sp++;
        end else begin
          r.push_back(mk(8'd0, 16'd0, 1'b1, ERR_OVF));
        end
      end else if (prio(16'(c)) > 0) begin
        if (sp < 2) begin
          r.push_back(mk(8'd0, 16'd0, 1'b1, ERR_UNF));
        end else begin
          a = longint'($signed(stk[sp-2]));
          b = longint'($signed(stk[sp-1]));
          case (c)
            CH_PLUS:  q = a + b;
            CH_MINUS: q = a - b;
            CH_STAR:  q = a * b;
            default: begin
              if (b == 0) ok = 1'b0;
              else q = a / b;
            end
          endcase
          if (!ok) begin
            r.push_back(mk(8'd0, 16'd0, 1'b1, ERR_DIV0));
          end else begin
            sp -= 2;
            stk[sp] = q[15:0];
            sp++;
          end
        end
      end else begin
        r.push_back(mk(8'd0, 16'd0, 1'b1, ERR_INV));
      end
      if (l) begin
        if (sp > 0) r.push_back(mk(8'd0, stk[sp-1], 1'b1, ERR_NONE));
        else r.push_back(mk(8'd0, 16'd0, 1'b1, ERR_UNF));
        r[r.size()-1].eor = 1'b1;
        sp = 0;
      end
    end
    if (keep) foreach (r[i]) pending_results.push_back(r[i]);
  endfunction

  function automatic void check(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [7:0] operand_char();
    case ($urandom_range(0, 2))
      0:       return CH_0 + 8'($urandom_range(0, 9));
      1:       return CH_LA + 8'($urandom_range(0, 25));
      default: return CH_UA + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] oper_char();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic str_t infix_expr();
    str_t s;
    int   n, i;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      s.push_back(operand_char());
      if (i < n - 1) s.push_back(oper_char());
    end
    return s;
  endfunction

  function automatic str_t postfix_expr();
    str_t s;
    int   d, ops, k;
    k = $urandom_range(0, 8);
    d = 0;
    ops = 0;
    while (!(ops >= k && d == 1)) begin
      if (d < 2 || (ops < k && d < 6 && $urandom_range(0, 1) == 1)) begin
        s.push_back(CH_0 + 8'($urandom_range(0, 9)));
        d++;
      end else begin
        s.push_back(oper_char());
        d--;
        ops++;
      end
    end
    return s;
  endfunction

  task automatic send_char(logic [7:0] c, logic l, bit typed, res_t want);
    int g;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      g = $urandom_range(1, 13);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      ch_i = 8'($urandom);
      last_i = 1'($urandom);
      repeat (g - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    ch_i = c;
    last_i = l;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    n_items++;
    engine_step(c, l, !typed);
    if (typed) pending_results.push_back(want);
  endtask

  task automatic issue(str_t s, bit open, bit noisy);
    logic [7:0] c;
    foreach (s[i]) begin
      c = s[i];
      if (noisy && $urandom_range(0, 11) == 0)
        c = ($urandom_range(0, 3) == 0) ? CH_HASH : 8'($urandom);
      send_char(c, (i == s.size() - 1) && !open, 1'b0, '0);
    end
  endtask

  task automatic settle();
    @(negedge clk_i) in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(logic m);
    logic [31:0] rd;
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = MODE_ADDR;
    pwdata = {31'($urandom), m};
    @(negedge clk_i) penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    mode_q = m;
    n_cfg++;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i) penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    check("mode readback", 16'(rd), 16'(m));
    if (rd[31:16] !== 16'd0) check("mode readback upper", 16'd0, rd[31:16]);
  endtask

  always @(posedge clk_i) begin : result_mon
    res_t e;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with no item pending: char %0h value %0h err %0d",
               out_char_o, result_value_o, error_code_o);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        check("out_char", 16'(e.chr), 16'(out_char_o));
        check("result_value", e.val, result_value_o);
        check("is_value", 16'(e.isv), 16'(is_value_o));
        check("error_code", 16'(e.err), 16'(error_code_o));
        check("end_of_run", 16'(e.eor), 16'(end_of_run_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : drain_ctl
    int n;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        @(negedge clk_i) out_ready_i = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 13);
        @(negedge clk_i) out_ready_i = 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        n = $urandom_range(1, 20);
        @(negedge clk_i) out_ready_i = 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  initial begin : stim
    str_t s;
    res_t want;
    logic md;
    bit   open;
    int   p, cnt;
    in_valid_i = 1'b0;
    ch_i = 8'd0;
    last_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'd0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].md != mode_q) begin
        settle();
        set_mode(dir_tab[i].md);
      end
      want = '{dir_tab[i].w_chr, dir_tab[i].w_val, dir_tab[i].w_isv,
               dir_tab[i].w_err, dir_tab[i].w_eor};
      send_char(dir_tab[i].ch, dir_tab[i].lst, dir_tab[i].typed, want);
    end

    // phase 1: long output stall; phase 2 fills the stack in evaluate mode and
    // leaves it there, phase 3 converts on top of it (overflow, 32-result flush)
    for (p = 0; p < NPHASE; p++) begin
      settle();
      quiet = (p >= NPHASE - 2);
      if (p == 1 || p == 3) md = 1'b0;
      else if (p == 2 || p == 4) md = 1'b1;
      else md = 1'($urandom_range(0, 1));
      set_mode(md);
      if (p == 1) hold_req = 1'b1;
      cnt = 0;
      if (p == 2) begin
        s = {};
        repeat (STACK_DEPTH + $urandom_range(1, 3))
          s.push_back(CH_0 + 8'($urandom_range(0, 9)));
        issue(s, 1'b1, 1'b0);
      end else begin
        if (p == 3) begin
          s = {oper_char(), operand_char()};
          issue(s, 1'b0, 1'b0);
        end else if (md) begin
          // 8^5 wraps to the most negative value, then divided by -1
          s = {CH_0 + 8'd8, CH_0 + 8'd8, CH_STAR, CH_0 + 8'd8, CH_STAR,
               CH_0 + 8'd8, CH_STAR, CH_0 + 8'd8, CH_STAR, CH_0, CH_0 + 8'd1,
               CH_MINUS, CH_SLASH};
          issue(s, 1'b0, 1'b0);
        end
        while (cnt < PHASE_ITEMS) begin
          s = md ? postfix_expr() : infix_expr();
          open = (cnt + s.size() >= PHASE_ITEMS) && ($urandom_range(0, 2) == 0);
          issue(s, open, 1'b1);
          cnt += s.size();
        end
      end
    end
    settle();

    $display("%0d characters sent, %0d results checked, %0d mode writes",
             n_items, n_results, n_cfg);
    $display("both modes, stack overflow/underflow, divide by zero, bad characters, %s",
             "wrapped quotient, stack kept across mode change, long output stall");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
